/* rtl/core/assert_macros.svh */
// assertion macros shared by the allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under active-low reset
`define SFBA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under active-low reset
`define SFBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/sfba_pkg.sv */
// shared types and constants of the sequential fit allocator
package sfba_pkg;

  localparam int unsigned POLICY_W  = 2;
  localparam int unsigned COUNT_W   = 11;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned IN_IDX_W  = 10;
  localparam int unsigned IN_SIZE_W = 16;

  localparam int unsigned QUEUE_DEPTH = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'd1;

  localparam logic [COUNT_W-1:0] ENTRY_COUNT_RST = 11'd1024;

  // fit policies
  localparam logic [POLICY_W-1:0] POL_FIRST  = 2'd0;
  localparam logic [POLICY_W-1:0] POL_BEST   = 2'd1;
  localparam logic [POLICY_W-1:0] POL_WORST  = 2'd2;
  localparam logic [POLICY_W-1:0] POL_SPARE  = 2'd3;

  // item kinds
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_ALLOC = 1'b1;

  typedef struct packed {
    logic [POLICY_W-1:0] fit_policy;
    logic [COUNT_W-1:0]  entry_count;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_SCAN  = 4'b0010,
    B_DRAIN = 4'b0100,
    B_WRITE = 4'b1000
  } back_state_t;

endpackage

/* rtl/core/sfba_front.sv */
// front end: accepts items, drops out-of-range loads and packs commands for the queue
module sfba_front #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned SIZE_BITS   = 16,
  localparam int unsigned IDX_W      = $clog2(TABLE_DEPTH),
  localparam int unsigned CMD_W      = 1 + IDX_W + SIZE_BITS
) (
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_req_type,
  input  logic [sfba_pkg::IN_IDX_W-1:0]      in_entry_index,
  input  logic [sfba_pkg::IN_SIZE_W-1:0]     in_entry_size,
  input  logic [sfba_pkg::IN_SIZE_W-1:0]     in_request_size,
  input  sfba_pkg::q_status_t                q_status,
  output logic                               push_valid,
  output logic [CMD_W-1:0]                   push_data
);

  logic [31:0]          idx32;
  logic [31:0]          size32;
  logic                 is_req;
  logic                 load_ok;
  logic [IDX_W-1:0]     idx;
  logic [SIZE_BITS-1:0] val;

  assign is_req  = (in_req_type == sfba_pkg::REQ_ALLOC);
  assign idx32   = 32'(in_entry_index);
  assign load_ok = idx32 < 32'(TABLE_DEPTH);
  assign idx     = idx32[IDX_W-1:0];
  // loads carry the entry size, requests the asked size
  assign size32  = is_req ? 32'(in_request_size) : 32'(in_entry_size);
  assign val     = size32[SIZE_BITS-1:0];

  assign in_stall   = q_status.full;
  assign push_valid = in_valid && (is_req || load_ok);
  assign push_data  = {is_req, idx, val};

endmodule

/* rtl/core/sfba_queue.sv */
// small command queue between the front end and the back end
`include "assert_macros.svh"

module sfba_queue #(
  parameter int unsigned W = 27,
  localparam int unsigned PTR_W = $clog2(sfba_pkg::QUEUE_DEPTH),
  localparam int unsigned CNT_W = $clog2(sfba_pkg::QUEUE_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  input  logic [W-1:0]        push_data,
  input  logic                pop,
  output sfba_pkg::q_status_t status,
  output logic [W-1:0]        pop_data
);

  logic [W-1:0]     slot_r [sfba_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push_ok;
  logic             pop_ok;

  assign status.full      = (count_r == CNT_W'(sfba_pkg::QUEUE_DEPTH));
  assign status.not_empty = (count_r != '0);
  assign push_ok  = push_valid && !status.full;
  assign pop_ok   = pop && status.not_empty;
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push_ok ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push_ok && !pop_ok) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop_ok && !push_ok) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  `SFBA_ASSERT_NOW(a_q_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(sfba_pkg::QUEUE_DEPTH), "queue count overflow")

endmodule

/* rtl/core/sfba_back.sv */
// back end: size table memory, fit scan, write-back and result register
`include "assert_macros.svh"

module sfba_back #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned SIZE_BITS   = 16,
  localparam int unsigned IDX_W      = $clog2(TABLE_DEPTH),
  localparam int unsigned CNT_W      = $clog2(TABLE_DEPTH + 1),
  localparam int unsigned CMD_W      = 1 + IDX_W + SIZE_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sfba_pkg::cfg_t                 cfg,
  input  sfba_pkg::q_status_t            q_status,
  input  logic [CMD_W-1:0]               pop_data,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_granted,
  output logic [sfba_pkg::IN_IDX_W-1:0]  out_chosen_index,
  output logic [sfba_pkg::IN_SIZE_W-1:0] out_remaining_size
);

  logic [SIZE_BITS-1:0] table_mem [TABLE_DEPTH];

  sfba_pkg::back_state_t state_r, state_nxt;
  logic [IDX_W-1:0]     addr_r, addr_nxt;
  logic                 rd_vld_r;
  logic [IDX_W-1:0]     rd_idx_r;
  logic [SIZE_BITS-1:0] rd_data_r;
  logic [SIZE_BITS-1:0] q_r, q_nxt;
  logic                 found_r, found_nxt;
  logic [SIZE_BITS-1:0] best_r, best_nxt;
  logic [IDX_W-1:0]     pick_r, pick_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_granted_r;
  logic [sfba_pkg::IN_IDX_W-1:0]  out_idx_r;
  logic [sfba_pkg::IN_SIZE_W-1:0] out_rem_r;

  logic                 cmd_is_req;
  logic [IDX_W-1:0]     cmd_idx;
  logic [SIZE_BITS-1:0] cmd_val;
  logic [31:0]          cnt32;
  logic [31:0]          n32;
  logic [CNT_W-1:0]     n;
  logic [CNT_W-1:0]     n_last;
  logic                 hit_ge;
  logic                 take;
  logic                 grant;
  logic [SIZE_BITS-1:0] diff;
  logic [31:0]          pick32;
  logic [31:0]          diff32;
  logic                 out_load;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [SIZE_BITS-1:0] mem_wdata;

  assign cmd_is_req = pop_data[CMD_W-1];
  assign cmd_idx    = pop_data[CMD_W-2 -: IDX_W];
  assign cmd_val    = pop_data[SIZE_BITS-1:0];

  // entries in use, clamped to the table depth
  assign cnt32  = 32'(cfg.entry_count);
  assign n32    = (cnt32 > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : cnt32;
  assign n      = n32[CNT_W-1:0];
  assign n_last = n - CNT_W'(1);

  assign pop = (state_r == sfba_pkg::B_IDLE) && q_status.not_empty;

  // evaluate the entry read in the previous cycle, scanning from the top down
  assign hit_ge = (rd_data_r >= q_r);
  always_comb begin
    case (cfg.fit_policy)
      sfba_pkg::POL_FIRST: take = hit_ge && !found_r;
      sfba_pkg::POL_BEST:  take = hit_ge && (!found_r || rd_data_r < best_r);
      default:             take = !found_r || rd_data_r > best_r;
    endcase
  end

  assign grant    = found_r && (best_r >= q_r);
  assign diff     = best_r - q_r;
  assign pick32   = 32'(pick_r);
  assign diff32   = 32'(diff);
  assign out_load = (state_r == sfba_pkg::B_WRITE) && (!out_valid_r || !out_stall);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cmd_idx;
    mem_wdata = cmd_val;
    if (pop && !cmd_is_req) begin
      mem_we = 1'b1;
    end else if (out_load && grant) begin
      mem_we    = 1'b1;
      mem_waddr = pick_r;
      mem_wdata = diff;
    end
  end

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    q_nxt     = q_r;
    found_nxt = found_r;
    best_nxt  = best_r;
    pick_nxt  = pick_r;
    if (rd_vld_r && take) begin
      found_nxt = 1'b1;
      best_nxt  = rd_data_r;
      pick_nxt  = rd_idx_r;
    end
    unique case (state_r)
      sfba_pkg::B_IDLE: begin
        if (pop && cmd_is_req) begin
          q_nxt     = cmd_val;
          found_nxt = 1'b0;
          addr_nxt  = n_last[IDX_W-1:0];
          state_nxt = (n == '0) ? sfba_pkg::B_WRITE : sfba_pkg::B_SCAN;
        end
      end
      sfba_pkg::B_SCAN: begin
        if (addr_r == '0) begin
          state_nxt = sfba_pkg::B_DRAIN;
        end else begin
          addr_nxt = addr_r - IDX_W'(1);
        end
      end
      sfba_pkg::B_DRAIN: begin
        state_nxt = sfba_pkg::B_WRITE;
      end
      sfba_pkg::B_WRITE: begin
        if (out_load) begin
          state_nxt = sfba_pkg::B_IDLE;
        end
      end
      default: begin
        state_nxt = sfba_pkg::B_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sfba_pkg::B_IDLE;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= (state_r == sfba_pkg::B_SCAN);
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r   <= addr_nxt;
    rd_idx_r <= addr_r;
    q_r      <= q_nxt;
    best_r   <= best_nxt;
    pick_r   <= pick_nxt;
    if (out_load) begin
      out_granted_r <= grant;
      out_idx_r     <= grant ? pick32[sfba_pkg::IN_IDX_W-1:0] : '0;
      out_rem_r     <= grant ? diff32[sfba_pkg::IN_SIZE_W-1:0] : '0;
    end
  end

  // size table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= table_mem[addr_r];
  end

  assign out_valid          = out_valid_r;
  assign out_granted        = out_granted_r;
  assign out_chosen_index   = out_idx_r;
  assign out_remaining_size = out_rem_r;

  `SFBA_ASSERT_NOW(a_scan_in_range, clk, rst_n, state_r == sfba_pkg::B_SCAN, CNT_W'(addr_r) < n, "scan address beyond entries in use")
  `SFBA_ASSERT_NEXT(a_drain_to_write, clk, rst_n, state_r == sfba_pkg::B_DRAIN, state_r == sfba_pkg::B_WRITE, "drain not followed by write-back")
  `SFBA_ASSERT_NEXT(a_result_posted, clk, rst_n, out_load, out_valid_r, "result not posted after write-back")

endmodule

/* rtl/core/sequential_fit_block_allocator.sv */
// top level of the sequential fit block allocator
//
// Input channel (in_valid / in_stall) takes load and request transactions.
// A load writes in_entry_size into entry in_entry_index; loads beyond the
// table depth are dropped. A request scans the entries in use from the top
// down under the fit policy, subtracts in_request_size from the chosen entry
// and posts one result transaction on out_valid / out_stall.
// Configuration: cfg_wr_en with cfg_index 0 writes the fit policy (first,
// best, worst fit), index 1 writes the number of entries in use. Write only
// while the block is idle.
// Back end: a load is written while it is idle; a request scans n entries
// (no scan and no drain when n is 0), n being entry_count clamped to the table depth:
// the scan reads one entry per cycle through the table's single read port,
// then a drain state and a write-back state follow before the next item.
// A two-entry queue lets input be taken while the back end scans. A stalled
// result holds in its register and blocks the next write-back only. Reset
// clears control state and sets policy to first fit and entry count to 1024;
// table contents stay undefined until loaded.
module sequential_fit_block_allocator #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned SIZE_BITS   = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [sfba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfba_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_req_type,
  input  logic [sfba_pkg::IN_IDX_W-1:0]   in_entry_index,
  input  logic [sfba_pkg::IN_SIZE_W-1:0]  in_entry_size,
  input  logic [sfba_pkg::IN_SIZE_W-1:0]  in_request_size,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_granted,
  output logic [sfba_pkg::IN_IDX_W-1:0]   out_chosen_index,
  output logic [sfba_pkg::IN_SIZE_W-1:0]  out_remaining_size
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CMD_W = 1 + IDX_W + SIZE_BITS;

  sfba_pkg::cfg_t      cfg_r, cfg_nxt;
  sfba_pkg::q_status_t q_status;
  logic                push_valid;
  logic [CMD_W-1:0]    push_data;
  logic                pop;
  logic [CMD_W-1:0]    pop_data;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        sfba_pkg::CFG_FIT_POLICY:  cfg_nxt.fit_policy  = cfg_data[sfba_pkg::POLICY_W-1:0];
        sfba_pkg::CFG_ENTRY_COUNT: cfg_nxt.entry_count = cfg_data[sfba_pkg::COUNT_W-1:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fit_policy  <= sfba_pkg::POL_FIRST;
      cfg_r.entry_count <= sfba_pkg::ENTRY_COUNT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sfba_front #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .SIZE_BITS   (SIZE_BITS)
  ) u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_entry_index  (in_entry_index),
    .in_entry_size   (in_entry_size),
    .in_request_size (in_request_size),
    .q_status        (q_status),
    .push_valid      (push_valid),
    .push_data       (push_data)
  );

  sfba_queue #(
    .W (CMD_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .pop        (pop),
    .status     (q_status),
    .pop_data   (pop_data)
  );

  sfba_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .SIZE_BITS   (SIZE_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .q_status           (q_status),
    .pop_data           (pop_data),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_granted        (out_granted),
    .out_chosen_index   (out_chosen_index),
    .out_remaining_size (out_remaining_size)
  );

endmodule

/* sim/sequential_fit_block_allocator_tb.sv */
`timescale 1ns / 100ps
// self-checking testbench for the sequential fit block allocator
module sequential_fit_block_allocator_tb;

  localparam int TABLE_DEPTH    = 1024;
  localparam int FILL_COUNT     = 64;
  localparam int DRAIN_CYCLES   = 16;
  localparam int TIMEOUT_CYCLES = 600_000;

  typedef logic [sfba_pkg::CFG_W-1:0]     cfg_word_t;
  typedef logic [sfba_pkg::IN_SIZE_W-1:0] size_word_t;
  typedef logic [sfba_pkg::IN_IDX_W-1:0]  idx_word_t;

  typedef struct packed {
    logic       req_type;
    idx_word_t  entry_index;
    size_word_t entry_size;
    size_word_t request_size;
  } alloc_item_t;

  typedef struct packed {
    logic       granted;
    idx_word_t  chosen_index;
    size_word_t remaining_size;
  } grant_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_wr_en = 1'b0;
  logic [sfba_pkg::CFG_IDX_W-1:0] cfg_index = sfba_pkg::CFG_FIT_POLICY;
  cfg_word_t                      cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           in_req_type = sfba_pkg::REQ_LOAD;
  idx_word_t                      in_entry_index = '0;
  size_word_t                     in_entry_size = '0;
  size_word_t                     in_request_size = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           out_granted;
  idx_word_t                      out_chosen_index;
  size_word_t                     out_remaining_size;

  alloc_item_t                    pending_items[$];
  grant_t                         expected_grants[$];
  size_word_t                     free_mirror [TABLE_DEPTH];
  logic [sfba_pkg::POLICY_W-1:0]  cur_policy = sfba_pkg::POL_FIRST;
  logic [sfba_pkg::COUNT_W-1:0]   cur_count = sfba_pkg::ENTRY_COUNT_RST;
  logic [sfba_pkg::POLICY_W-1:0]  policy_order [4] = '{sfba_pkg::POL_FIRST,
      sfba_pkg::POL_BEST, sfba_pkg::POL_WORST, sfba_pkg::POL_SPARE};
  bit                             in_fired = 1'b0;
  int                             send_idle_pct = 0;
  int                             recv_stall_pct = 0;
  int                             mismatch_count = 0;

  sequential_fit_block_allocator u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_entry_index     (in_entry_index),
    .in_entry_size      (in_entry_size),
    .in_request_size    (in_request_size),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_granted        (out_granted),
    .out_chosen_index   (out_chosen_index),
    .out_remaining_size (out_remaining_size)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // picks an entry under the current policy and takes the request out of it
  function automatic grant_t predict_allocation(input size_word_t want);
    grant_t g;
    int     span;
    int     pick;
    bit     hit;
    g = '0;
    pick = 0;
    hit = 1'b0;
    span = (cur_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(cur_count);
    for (int e = span - 1; e >= 0; e--) begin
      if (cur_policy == sfba_pkg::POL_FIRST) begin
        if (free_mirror[e] >= want) begin
          pick = e;
          hit = 1'b1;
          break;
        end
      end else if (cur_policy == sfba_pkg::POL_BEST) begin
        if (free_mirror[e] >= want && (!hit || free_mirror[e] < free_mirror[pick])) begin
          pick = e;
          hit = 1'b1;
        end
      end else if (!hit || free_mirror[e] > free_mirror[pick]) begin
        // worst fit, the spare code included; strict compare keeps the top index on ties
        pick = e;
        hit = 1'b1;
      end
    end
    if (hit && free_mirror[pick] >= want) begin
      free_mirror[pick] = free_mirror[pick] - want;
      g.granted = 1'b1;
      g.chosen_index = pick[sfba_pkg::IN_IDX_W-1:0];
      g.remaining_size = free_mirror[pick];
    end
    return g;
  endfunction

  // biased toward zero, full scale and small values so ties and exact fits show up
  function automatic size_word_t rand_size();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 20) return '1;
    if (roll < 45) return size_word_t'($urandom_range(0, 8));
    if (roll < 70) return size_word_t'($urandom_range(0, 2000));
    return size_word_t'($urandom_range(0, 65535));
  endfunction

  function automatic void push_load(input int idx, input size_word_t size);
    alloc_item_t it;
    it.req_type = sfba_pkg::REQ_LOAD;
    it.entry_index = idx[sfba_pkg::IN_IDX_W-1:0];
    it.entry_size = size;
    it.request_size = size_word_t'($urandom_range(0, 65535));
    pending_items.push_back(it);
  endfunction

  function automatic void push_request(input size_word_t size);
    alloc_item_t it;
    it.req_type = sfba_pkg::REQ_ALLOC;
    it.entry_index = idx_word_t'($urandom_range(0, TABLE_DEPTH - 1));
    it.entry_size = size_word_t'($urandom_range(0, 65535));
    it.request_size = size;
    pending_items.push_back(it);
  endfunction

  // loads give no result, so leave room for trailing ones after the last result
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_grants.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_cfg(input logic [sfba_pkg::CFG_IDX_W-1:0] reg_idx,
                         input cfg_word_t value);
    wait_idle();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= reg_idx;
    cfg_data <= value;
    if (reg_idx == sfba_pkg::CFG_FIT_POLICY) cur_policy = value[sfba_pkg::POLICY_W-1:0];
    else cur_count = value[sfba_pkg::COUNT_W-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  always @(negedge clk) begin : drive_items
    alloc_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fired) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        it = pending_items.pop_front();
        in_valid <= 1'b1;
        in_req_type <= it.req_type;
        in_entry_index <= it.entry_index;
        in_entry_size <= it.entry_size;
        in_request_size <= it.request_size;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin : check_results
    grant_t want;
    if (!rst_n) begin
      in_fired = 1'b0;
    end else begin
      in_fired = in_valid && !in_stall;
      if (in_fired) begin
        if (in_req_type == sfba_pkg::REQ_LOAD) free_mirror[in_entry_index] = in_entry_size;
        else expected_grants.push_back(predict_allocation(in_request_size));
      end
      if (out_valid && !out_stall) begin
        if (expected_grants.size() == 0) begin
          $error("result transaction with no request outstanding: granted %0d index %0d size %0d",
                 out_granted, out_chosen_index, out_remaining_size);
          mismatch_count++;
        end else begin
          want = expected_grants.pop_front();
          if (out_granted !== want.granted) begin
            $error("granted: expected %0d, got %0d", want.granted, out_granted);
            mismatch_count++;
          end
          if (out_chosen_index !== want.chosen_index) begin
            $error("chosen_index: expected %0d, got %0d", want.chosen_index, out_chosen_index);
            mismatch_count++;
          end
          if (out_remaining_size !== want.remaining_size) begin
            $error("remaining_size: expected %0d, got %0d",
                   want.remaining_size, out_remaining_size);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin : stimulus
    int        span;
    int        burst;
    cfg_word_t count_pick;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // scans stay inside the filled low entries, so none meets an entry never loaded
    set_cfg(sfba_pkg::CFG_ENTRY_COUNT, cfg_word_t'(FILL_COUNT));
    for (int i = 0; i < FILL_COUNT; i++) push_load(i, size_word_t'($urandom_range(0, 65535)));

    // reset policy: first fit over the filled entries
    push_request('0);
    push_request('1);
    push_load(FILL_COUNT - 1, '1);
    push_load(0, '0);
    push_request('1);

    set_cfg(sfba_pkg::CFG_ENTRY_COUNT, cfg_word_t'(4));
    push_load(0, '1);
    push_load(1, '0);
    push_load(2, size_word_t'(300));
    push_load(3, size_word_t'(300));
    push_request(size_word_t'(200));
    push_request(size_word_t'(301));
    set_cfg(sfba_pkg::CFG_FIT_POLICY, cfg_word_t'(sfba_pkg::POL_BEST));
    push_request(size_word_t'(100));
    push_load(2, size_word_t'(50));
    push_load(3, size_word_t'(50));
    push_request(size_word_t'(50));
    push_request('0);
    set_cfg(sfba_pkg::CFG_FIT_POLICY, cfg_word_t'(sfba_pkg::POL_WORST));
    push_request(size_word_t'(10));
    push_request('1);
    set_cfg(sfba_pkg::CFG_FIT_POLICY, cfg_word_t'(sfba_pkg::POL_SPARE));
    push_request(size_word_t'(1));
    set_cfg(sfba_pkg::CFG_ENTRY_COUNT, cfg_word_t'(0));
    push_request(size_word_t'(5));
    push_request('0);
    set_cfg(sfba_pkg::CFG_ENTRY_COUNT, cfg_word_t'(FILL_COUNT));
    push_request('0);

    // random bursts; every config change waits for all results, so the sender pauses
    for (int chunk = 0; chunk < 25; chunk++) begin
      case (chunk % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 57;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 57;
        end
        default: begin
          send_idle_pct = 21;
          recv_stall_pct = 21;
        end
      endcase
      set_cfg(sfba_pkg::CFG_FIT_POLICY,
              cfg_word_t'(policy_order[chunk < 4 ? chunk : $urandom_range(0, 3)]));
      if (chunk == 2) count_pick = cfg_word_t'(1);
      else if (chunk == 6) count_pick = cfg_word_t'(FILL_COUNT);
      else if (chunk == 13) count_pick = cfg_word_t'(FILL_COUNT);
      else if (chunk == 19) count_pick = cfg_word_t'(0);
      else if ($urandom_range(99) < 60) count_pick = cfg_word_t'($urandom_range(1, 8));
      else count_pick = cfg_word_t'($urandom_range(9, 48));
      set_cfg(sfba_pkg::CFG_ENTRY_COUNT, count_pick);
      span = (count_pick > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_pick);
      burst = 15;
      for (int k = 0; k < burst; k++) begin
        if ($urandom_range(1) == 1)
          push_request(rand_size());
        else if (span > 0 && $urandom_range(99) < 70)
          push_load(int'($urandom_range(0, span - 1)), rand_size());
        else
          push_load(int'($urandom_range(0, TABLE_DEPTH - 1)), rand_size());
      end
    end

    wait_idle();
    if (mismatch_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #(12 * TIMEOUT_CYCLES);
    $display("FAIL");
    $finish;
  end

endmodule
